>>> rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccW   = 21;
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = 2;

  localparam logic [UnitW-1:0] HiSurBase = 16'hd800;
  localparam logic [UnitW-1:0] LoSurBase = 16'hdc00;
  localparam logic [AccW-1:0]  SupOffset = 21'h10000;

  localparam logic [ByteW-1:0] LeadMask2 = 8'he0;
  localparam logic [ByteW-1:0] LeadCode2 = 8'hc0;
  localparam logic [ByteW-1:0] LeadMask3 = 8'hf0;
  localparam logic [ByteW-1:0] LeadCode3 = 8'he0;

  // continuation bytes still expected
  localparam logic [1:0] PendLead = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_of_char;
    logic             end_of_string;
  } u8u16_unit_t;

endpackage

>>> rtl/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for the byte input and the code unit output.
// ----------------------------------------------------------------------------
interface u8u16_in_if
  import u8u16_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             last_of_char;
  logic             end_of_string;

  modport source (output valid, output code_unit, output last_of_char,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input last_of_char,
                  input end_of_string, output ready);
endinterface

>>> rtl/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Non-validating UTF-8 byte stream to UTF-16 code unit decoder.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while input ready is high and emits UTF-16 code
// units through a three-entry output queue. Each byte is decoded in the cycle
// it is accepted; its units (none, one, or a surrogate pair) are queued.
// Sustained rate is one byte per cycle while the output side takes a unit per
// cycle; the queue absorbs the extra unit of a surrogate pair. Input ready
// drops only when the queue cannot take two more units. A zero byte at a lead
// position yields a zero terminator flagged with end_of_string.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  logic [1:0]      pend_r, pend_nxt;
  logic            four_r, four_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;

  u8u16_unit_t     q_r [QDepth];
  u8u16_unit_t     q_nxt [QDepth];
  u8u16_unit_t     shifted [QDepth];
  logic [QCntW-1:0] cnt_r, cnt_nxt, cnt_pop;

  logic            in_acc, pop;
  logic [1:0]      push_n;
  u8u16_unit_t     unit0, unit1;
  logic [ByteW-1:0] b;
  logic [AccW-1:0] acc_cont, sup_val;

  assign b      = in_ch.in_byte;
  assign pop    = out_ch.valid && out_ch.ready;
  assign cnt_pop = cnt_r - QCntW'(pop);
  // room for a surrogate pair after this cycle's pop
  assign in_ch.ready = (cnt_r <= QCntW'(1)) || (cnt_r == QCntW'(2) && out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign acc_cont = {acc_r[AccW-7:0], b[5:0]};
  assign sup_val  = acc_cont - SupOffset;

  always_comb begin
    pend_nxt = pend_r;
    four_nxt = four_r;
    acc_nxt  = acc_r;
    push_n   = 2'd0;
    unit0    = '0;
    unit1    = '0;
    if (in_acc) begin
      if (pend_r == PendLead) begin
        if (b[7] == 1'b0) begin
          push_n = 2'd1;
          unit0.code_unit     = {{(UnitW-ByteW){1'b0}}, b};
          unit0.last_of_char  = 1'b1;
          unit0.end_of_string = (b == '0);
        end else if ((b & LeadMask2) == LeadCode2) begin
          acc_nxt  = {{(AccW-5){1'b0}}, b[4:0]};
          pend_nxt = PendOne;
          four_nxt = 1'b0;
        end else if ((b & LeadMask3) == LeadCode3) begin
          acc_nxt  = {{(AccW-4){1'b0}}, b[3:0]};
          pend_nxt = PendTwo;
          four_nxt = 1'b0;
        end else begin
          acc_nxt  = {{(AccW-3){1'b0}}, b[2:0]};
          pend_nxt = PendThree;
          four_nxt = 1'b1;
        end
      end else begin
        acc_nxt  = acc_cont;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == PendOne) begin
          acc_nxt = '0;
          if (four_r) begin
            four_nxt = 1'b0;
            push_n   = 2'd2;
            unit0.code_unit    = HiSurBase | {6'd0, sup_val[19:10]};
            unit1.code_unit    = LoSurBase | {6'd0, acc_cont[9:0]};
            unit1.last_of_char = 1'b1;
          end else begin
            push_n = 2'd1;
            unit0.code_unit    = acc_cont[UnitW-1:0];
            unit0.last_of_char = 1'b1;
          end
        end
      end
    end
  end

  // queue: shift out on pop, then append at the new tail
  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      shifted[i] = pop ? q_r[i+1] : q_r[i];
    end
    shifted[QDepth-1] = q_r[QDepth-1];
    for (int i = 0; i < QDepth; i++) begin
      q_nxt[i] = shifted[i];
      if (push_n != 2'd0 && QCntW'(i) == cnt_pop) q_nxt[i] = unit0;
      if (push_n == 2'd2 && QCntW'(i) == cnt_pop + QCntW'(1)) q_nxt[i] = unit1;
    end
    cnt_nxt = cnt_pop + QCntW'(push_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PendLead;
      four_r <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      four_r <= four_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) q_r[i] <= q_nxt[i];
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.code_unit     = q_r[0].code_unit;
  assign out_ch.last_of_char  = q_r[0].last_of_char;
  assign out_ch.end_of_string = q_r[0].end_of_string;

  // a beat is only taken when the queue has room for a surrogate pair
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r <= QCntW'(1) || (cnt_r == QCntW'(2) && pop)))
    else $error("input beat accepted without queue room");

  // a high surrogate at the head always has its low half queued behind it
  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last_of_char) |-> (cnt_r >= QCntW'(2)))
    else $error("high surrogate without low surrogate");

  a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_string) |->
      (out_ch.code_unit == '0 && out_ch.last_of_char))
    else $error("malformed terminator");

  a_reset_lead: assert property (@(posedge clk)
    $past(!rst_n) |-> (pend_r == PendLead && cnt_r == '0))
    else $error("not at lead position after reset");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams random and hand-picked UTF-8 bytes into the transcoder. Each byte
// accepted is decoded in a scoreboard, and every code unit that comes out is
// checked against the oldest unit still due.
// ----------------------------------------------------------------------------
module testbench
  import u8u16_pkg::*;
();

  localparam int unsigned ByteTarget = 850;
  localparam int unsigned CalmBytes  = 150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 16;
  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ByteW-1:0] NulByte    = 8'h00;

  class utf16_unit_scoreboard;
    u8u16_unit_t      units_due[$];
    logic [1:0]       cont_left;
    logic             four_byte;
    logic [AccW-1:0]  code_point;
    int unsigned      errors;

    function new();
      cont_left  = PendLead;
      four_byte  = 1'b0;
      code_point = '0;
      errors     = 0;
    endfunction

    function void push_unit(logic [UnitW-1:0] cu, logic last, logic eos);
      u8u16_unit_t u;
      u.code_unit     = cu;
      u.last_of_char  = last;
      u.end_of_string = eos;
      units_due.push_back(u);
    endfunction

    // one accepted input beat
    function void decode_byte(logic [ByteW-1:0] b);
      logic [AccW-1:0] offs;
      if (cont_left == PendLead) begin
        if (b == NulByte) begin
          push_unit('0, 1'b1, 1'b1);
        end else if (b < AsciiLimit) begin
          push_unit({8'h00, b}, 1'b1, 1'b0);
        end else if ((b & LeadMask2) == LeadCode2) begin
          code_point = AccW'(b[4:0]);
          cont_left  = PendOne;
          four_byte  = 1'b0;
        end else if ((b & LeadMask3) == LeadCode3) begin
          code_point = AccW'(b[3:0]);
          cont_left  = PendTwo;
          four_byte  = 1'b0;
        end else begin
          // stray continuation and f8..ff leads land here too
          code_point = AccW'(b[2:0]);
          cont_left  = PendThree;
          four_byte  = 1'b1;
        end
        return;
      end
      code_point = {code_point[AccW-7:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left != PendLead) return;
      if (four_byte) begin
        offs = code_point - SupOffset;  // wraps for values below 0x10000
        push_unit(HiSurBase | UnitW'(offs[19:10]), 1'b0, 1'b0);
        push_unit(LoSurBase | UnitW'(code_point[9:0]), 1'b1, 1'b0);
        four_byte = 1'b0;
      end else begin
        push_unit(code_point[UnitW-1:0], 1'b1, 1'b0);
      end
      code_point = '0;
    endfunction

    function void check_unit(u8u16_unit_t got);
      u8u16_unit_t want;
      if (units_due.size() == 0) begin
        $display("%0t: unexpected unit: expected none, actual %h/%b/%b", $time,
                 got.code_unit, got.last_of_char, got.end_of_string);
        errors++;
        return;
      end
      want = units_due.pop_front();
      if (got.code_unit != want.code_unit) begin
        $display("%0t: code_unit expected %h actual %h", $time,
                 want.code_unit, got.code_unit);
        errors++;
      end
      if (got.last_of_char != want.last_of_char) begin
        $display("%0t: last_of_char expected %b actual %b", $time,
                 want.last_of_char, got.last_of_char);
        errors++;
      end
      if (got.end_of_string != want.end_of_string) begin
        $display("%0t: end_of_string expected %b actual %b", $time,
                 want.end_of_string, got.end_of_string);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_transcoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf16_unit_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  bit          calm        = 1'b0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // beat monitor: note inputs before checking outputs of the same edge
  always @(posedge clk) begin
    u8u16_unit_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.decode_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.code_unit     = out_ch.code_unit;
        got.last_of_char  = out_ch.last_of_char;
        got.end_of_string = out_ch.end_of_string;
        sb.check_unit(got);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0 && !calm) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct)
          stall_left = $urandom_range(1, 13);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_cont(input bit clean);
    if (clean) send_byte({2'b10, 6'($urandom_range(0, 63))});
    else       send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.units_due.size() != 0);
  endtask

  // mostly well-formed characters, some stray and broken bytes
  task automatic send_random_char();
    int unsigned kind;
    int unsigned pick;
    bit          clean;
    kind  = $urandom_range(0, 99);
    clean = ($urandom_range(0, 9) != 0);
    if (kind < 8) begin
      send_byte(NulByte);
    end else if (kind < 30) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 50) begin
      send_byte({3'b110, 5'($urandom_range(0, 31))});
      send_cont(clean);
    end else if (kind < 68) begin
      send_byte({4'b1110, 4'($urandom_range(0, 15))});
      repeat (2) send_cont(clean);
    end else if (kind < 88) begin
      pick = $urandom_range(0, 3);
      if (pick < 2)       send_byte({5'b11110, 3'($urandom_range(0, 7))});
      else if (pick == 2) send_byte({2'b10, 6'($urandom_range(0, 63))});
      else                send_byte({5'b11111, 3'($urandom_range(0, 7))});
      repeat (3) send_cont(clean);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [ByteW-1:0] directed[$];
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascii edges, terminator, 2/3/4-byte chars, stray continuation lead with
    // a zero inside, invalid lead giving a value below 0x10000, zero in a pair
    directed = '{8'h01, 8'h7f, 8'h00, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hbf, 8'h00, 8'hff, 8'h3f,
                 8'hf8, 8'h80, 8'h80, 8'h80, 8'hdf, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    gap_pct   = 20;
    stall_pct = 20;
    while (bytes_sent < 300) send_random_char();
    wait_drained();

    gap_pct   = 0;
    stall_pct = 40;
    while (bytes_sent < 500) send_random_char();

    gap_pct   = 50;
    stall_pct = 0;
    while (bytes_sent < ByteTarget - CalmBytes) send_random_char();

    calm = 1'b1;
    while (bytes_sent < ByteTarget) send_random_char();

    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/utf8_to_utf16_transcoder_core.sv
tb/testbench.sv
